FILE: sv/iis_pkg.sv
// Package for the integer index sorter: widths, capacity and the front-to-back command type.
// No dependencies.
package iis_pkg;
   localparam int MAX_ELEMENTS = 64;
   localparam int POS_W = 6;
   localparam int CNT_W = 7;
   localparam int VAL_W = 32;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic                    last;
   } cmd_type;
endpackage

FILE: sv/iis_if.sv
// Valid/ready channel interfaces for the sorter.
// Depends on iis_pkg.
interface iis_req_if import iis_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] value;
   logic                    last;
   modport source (output valid, value, last, input ready);
   modport sink (input valid, value, last, output ready);
endinterface

interface iis_rsp_if import iis_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] sorted_value;
   logic                    overflow;
   logic                    final_res;
   modport source (output valid, position, sorted_value, overflow, final_res, input ready);
   modport sink (input valid, position, sorted_value, overflow, final_res, output ready);
endinterface

FILE: sv/integer_index_sorter.sv
// Integer index sorter top level: request queue, insertion cell chain, result register.
// Depends on iis_pkg, iis_if, iis_queue, iis_cells, iis_out.
//
// Usage:
//  req channel: one signed 32-bit value per request; last closes the set.
//  rsp channel: one result per stored element, ascending by value, equal values
//    lower arrival position first; position is the arrival index, overflow is
//    set on every result of a set that exceeded 64 elements (extras dropped),
//    final_res marks the last result.
//  Loading: the cell chain inserts one element per cycle; a two-entry queue
//    sits in front, so requests flow at one per cycle while loading.
//  Emitting: after last, one result per cycle while rsp.ready is high;
//    requests wait in the queue until the set is drained.
//  The cell chain loads and emits in turn: a new set is not loaded until
//    the set before it has been shifted out completely.
//  Reset clears the count, overflow and all handshake state; stored values
//    need no clearing. A stalled rsp.ready holds the result register and
//    freezes the chain; nothing is lost.
module integer_index_sorter import iis_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   iis_req_if.sink   req,
   iis_rsp_if.source rsp
);
   cmd_type                 q_in, q_out;
   logic                    q_valid, q_ready;
   logic                    c_valid, c_ready;
   logic [POS_W-1:0]        c_pos;
   logic signed [VAL_W-1:0] c_val;
   logic                    c_ovf, c_fin;

   assign q_in.value = req.value;
   assign q_in.last  = req.last;

   // front: buffer requests
   iis_queue u_queue (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_cmd(q_in),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_out)
   );

   // back: sorted insertion and shift-out
   iis_cells u_cells (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_cmd(q_out),
      .out_valid(c_valid), .out_ready(c_ready),
      .out_position(c_pos), .out_value(c_val), .out_overflow(c_ovf), .out_final(c_fin)
   );

   iis_out u_out (
      .clock(clock), .reset(reset),
      .in_valid(c_valid), .in_ready(c_ready),
      .in_position(c_pos), .in_value(c_val), .in_overflow(c_ovf), .in_final(c_fin),
      .rsp(rsp)
   );
endmodule

FILE: sv/iis_queue.sv
// Two-entry request queue between front end and sort cells.
// Depends on iis_pkg.
module iis_queue import iis_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    out_valid,
   input  logic    out_ready,
   output cmd_type out_cmd
);
   cmd_type    mem_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, rp_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 2'd1;
      else if (pop && !push) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_cmd;
      if (reset) begin
         cnt_ff <= '0;
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= ~wp_ff;
         if (pop) rp_ff <= ~rp_ff;
      end
   end
endmodule

FILE: sv/iis_cells.sv
// Insertion cell chain: sorted storage, loads one element a cycle, then shifts out.
// Depends on iis_pkg.
module iis_cells import iis_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  cmd_type                 in_cmd,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [POS_W-1:0]        out_position,
   output logic signed [VAL_W-1:0] out_value,
   output logic                    out_overflow,
   output logic                    out_final
);
   localparam logic [1:0] ST_LOAD = 2'd0;
   localparam logic [1:0] ST_EMIT = 2'd1;

   logic signed [VAL_W-1:0] val_ff [MAX_ELEMENTS];
   logic [POS_W-1:0]        pos_ff [MAX_ELEMENTS];
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        left_ff, left_in;
   logic                    ovf_ff, ovf_in;
   logic [1:0]              state_ff, state_in;
   logic                    gt [MAX_ELEMENTS];
   logic                    take, full, pop;

   assign full     = (cnt_ff == CNT_W'(MAX_ELEMENTS));
   assign in_ready = (state_ff == ST_LOAD);
   assign take     = in_valid && in_ready;

   assign out_valid    = (state_ff == ST_EMIT);
   assign out_position = pos_ff[0];
   assign out_value    = val_ff[0];
   assign out_overflow = ovf_ff;
   assign out_final    = (left_ff == CNT_W'(1));
   assign pop          = out_valid && out_ready;

   // Each occupied cell flags whether it holds a strictly larger value (ties stay ahead).
   always_comb begin
      for (int i = 0; i < MAX_ELEMENTS; i++)
         gt[i] = (CNT_W'(i) < cnt_ff) && (val_ff[i] > in_cmd.value);
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         ST_LOAD: begin
            if (take) begin
               if (full) ovf_in = 1'b1;
               else cnt_in = cnt_ff + CNT_W'(1);
               if (in_cmd.last) begin
                  state_in = ST_EMIT;
                  left_in  = full ? cnt_ff : cnt_ff + CNT_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if (pop) begin
               left_in = left_ff - CNT_W'(1);
               if (left_ff == CNT_W'(1)) begin
                  state_in = ST_LOAD;
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // A cell whose left neighbor is larger takes that neighbor; the first larger
   // cell (or the first free one) takes the new element.
   always_ff @(posedge clock) begin
      if (take && !full) begin
         if (gt[0] || cnt_ff == '0) begin
            val_ff[0] <= in_cmd.value;
            pos_ff[0] <= cnt_ff[POS_W-1:0];
         end
         for (int i = 1; i < MAX_ELEMENTS; i++) begin
            if (gt[i-1]) begin
               val_ff[i] <= val_ff[i-1];
               pos_ff[i] <= pos_ff[i-1];
            end else if (gt[i] || CNT_W'(i) == cnt_ff) begin
               val_ff[i] <= in_cmd.value;
               pos_ff[i] <= cnt_ff[POS_W-1:0];
            end
         end
      end else if (pop) begin
         for (int i = 0; i + 1 < MAX_ELEMENTS; i++) begin
            val_ff[i] <= val_ff[i+1];
            pos_ff[i] <= pos_ff[i+1];
         end
      end
      if (reset) begin
         state_ff <= ST_LOAD;
         cnt_ff   <= '0;
         left_ff  <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
         ovf_ff   <= ovf_in;
      end
   end
endmodule

FILE: sv/iis_out.sv
// Result output register between cell chain and the response channel.
// Depends on iis_pkg.
module iis_out import iis_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [POS_W-1:0]        in_position,
   input  logic signed [VAL_W-1:0] in_value,
   input  logic                    in_overflow,
   input  logic                    in_final,
   iis_rsp_if.source               rsp
);
   logic                    vld_ff;
   logic [POS_W-1:0]        pos_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic                    ovf_ff, fin_ff;

   assign in_ready         = !vld_ff || rsp.ready;
   assign rsp.valid        = vld_ff;
   assign rsp.position     = pos_ff;
   assign rsp.sorted_value = val_ff;
   assign rsp.overflow     = ovf_ff;
   assign rsp.final_res    = fin_ff;

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         pos_ff <= in_position;
         val_ff <= in_value;
         ovf_ff <= in_overflow;
         fin_ff <= in_final;
      end
      if (reset) vld_ff <= 1'b0;
      else if (in_ready) vld_ff <= in_valid;
   end
endmodule
